// ----- hdl/dsrc_pkg.sv -----
// ---------------------------------------------------------------------------
// dsrc_pkg
// Shared types, widths and helpers for the dna symbol range counter.
// ---------------------------------------------------------------------------
package dsrc_pkg;

  localparam int WORD_W   = 64;
  localparam int SYMS     = 128;
  localparam int BLOCK_W  = 2 * SYMS;
  localparam int POS_W    = 8;
  localparam int CNT_W    = 8;
  localparam int CHUNK_W  = 16;
  localparam int N_CHUNK  = SYMS / CHUNK_W;
  localparam int PC_W     = $clog2(CHUNK_W + 1);
  localparam int N_LANE   = 4;
  localparam int ADDR_W   = 3;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(SYMS);

  // symbol codes
  localparam logic [1:0] SYM_A = 2'd0;
  localparam logic [1:0] SYM_C = 2'd1;
  localparam logic [1:0] SYM_G = 2'd2;
  localparam logic [1:0] SYM_T = 2'd3;

  // count lanes
  localparam int LANE_SEL = 0;
  localparam int LANE_C   = 1;
  localparam int LANE_G   = 2;
  localparam int LANE_T   = 3;

  // register indexes
  localparam logic REG_COUNT_ALL = 1'b0;

  typedef struct packed {
    logic               mode;
    logic [1:0]         symbol;
    logic [POS_W-1:0]   lo;
    logic [POS_W-1:0]   hi;
    logic [BLOCK_W-1:0] syms;
  } s1_t;

  typedef struct packed {
    logic                         mode;
    logic [POS_W-1:0]             len;
    logic [N_LANE-1:0][SYMS-1:0]  hits;
  } s2_t;

  typedef struct packed {
    logic                                     mode;
    logic [POS_W-1:0]                         len;
    logic [N_LANE-1:0][N_CHUNK-1:0][PC_W-1:0] part;
  } s3_t;

  typedef struct packed {
    logic                         mode;
    logic [POS_W-1:0]             len;
    logic [N_LANE-1:0][CNT_W-1:0] cnt;
  } s4_t;

  function automatic logic [PC_W-1:0] pop_chunk(input logic [CHUNK_W-1:0] x);
    logic [PC_W-1:0] n;
    n = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      n = n + PC_W'(x[i]);
    end
    return n;
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W-1:0] p);
    return (p > POS_MAX) ? POS_MAX : p;
  endfunction

endpackage

// ----- hdl/dna_symbol_range_count.sv -----
// ---------------------------------------------------------------------------
// dna_symbol_range_count
// Counts symbols of a 128-symbol dna block between two positions.
// ---------------------------------------------------------------------------
// Usage:
//   A query word is taken at every rising edge with start high and busy low.
//   busy never rises, so a new word can be issued in every cycle.
//   Each query gives one result word on the out_ ports, flagged by out_valid
//   for exactly one cycle; the receiver must take it then, it cannot stall.
//   Each query passes through the registered steps clamp/sort, range mask and
//   match, chunk popcount, chunk sum, and the output register that forms
//   count_a and applies the mode.
//   Throughput is one word per cycle, set by the fully pipelined datapath.
//   count_all_mode sits at byte address 0 of the apb port; write it only
//   while no query is in flight. Reset clears the register (selected symbol
//   only) and empties the pipeline; nothing in flight survives reset.
// ---------------------------------------------------------------------------
module dna_symbol_range_count (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dsrc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [dsrc_pkg::WORD_W-1:0]   in_block_bits_0,
  input  logic [dsrc_pkg::WORD_W-1:0]   in_block_bits_1,
  input  logic [dsrc_pkg::WORD_W-1:0]   in_block_bits_2,
  input  logic [dsrc_pkg::WORD_W-1:0]   in_block_bits_3,
  input  logic [dsrc_pkg::POS_W-1:0]    in_first_position,
  input  logic [dsrc_pkg::POS_W-1:0]    in_second_position,
  input  logic [1:0]                    in_symbol,
  output logic                          out_valid,
  output logic [dsrc_pkg::CNT_W-1:0]    out_selected_count,
  output logic [dsrc_pkg::CNT_W-1:0]    out_count_a,
  output logic [dsrc_pkg::CNT_W-1:0]    out_count_c,
  output logic [dsrc_pkg::CNT_W-1:0]    out_count_g,
  output logic [dsrc_pkg::CNT_W-1:0]    out_count_t
);
  import dsrc_pkg::*;

  logic             mode_r;
  logic             take;
  logic             vld1;
  logic             vld2;
  logic             vld4;
  s1_t              s1;
  s2_t              s2;
  s4_t              s4;
  logic             out_valid_r;
  logic [CNT_W-1:0] sel_r;
  logic [CNT_W-1:0] a_r;
  logic [CNT_W-1:0] c_r;
  logic [CNT_W-1:0] g_r;
  logic [CNT_W-1:0] t_r;
  logic [CNT_W-1:0] a_nxt;
  logic             reg_hit;

  // configuration port
  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_COUNT_ALL);
  assign prdata  = reg_hit ? {31'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      mode_r <= pwdata[0];
    end
  end

  assign busy = 1'b0;
  assign take = start && !busy;

  dsrc_sort u_sort (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .mode   (mode_r),
    .bits_0 (in_block_bits_0),
    .bits_1 (in_block_bits_1),
    .bits_2 (in_block_bits_2),
    .bits_3 (in_block_bits_3),
    .pos_a  (in_first_position),
    .pos_b  (in_second_position),
    .symbol (in_symbol),
    .vld    (vld1),
    .s1     (s1)
  );

  dsrc_match u_match (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_in (vld1),
    .s1     (s1),
    .vld    (vld2),
    .s2     (s2)
  );

  dsrc_popcount u_popcount (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_in (vld2),
    .s2     (s2),
    .vld    (vld4),
    .s4     (s4)
  );

  // a is whatever of the range is not c, g or t
  assign a_nxt = s4.len - s4.cnt[LANE_C] - s4.cnt[LANE_G] - s4.cnt[LANE_T];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    if (vld4) begin
      sel_r <= s4.cnt[LANE_SEL];
      a_r   <= s4.mode ? a_nxt : '0;
      c_r   <= s4.mode ? s4.cnt[LANE_C] : '0;
      g_r   <= s4.mode ? s4.cnt[LANE_G] : '0;
      t_r   <= s4.mode ? s4.cnt[LANE_T] : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_selected_count = sel_r;
  assign out_count_a        = a_r;
  assign out_count_c        = c_r;
  assign out_count_g        = g_r;
  assign out_count_t        = t_r;

endmodule

// ----- hdl/dsrc_sort.sv -----
// ---------------------------------------------------------------------------
// dsrc_sort
// Stage 1: clamps both positions, orders them and registers the block.
// ---------------------------------------------------------------------------
module dsrc_sort (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic                          mode,
  input  logic [dsrc_pkg::WORD_W-1:0]   bits_0,
  input  logic [dsrc_pkg::WORD_W-1:0]   bits_1,
  input  logic [dsrc_pkg::WORD_W-1:0]   bits_2,
  input  logic [dsrc_pkg::WORD_W-1:0]   bits_3,
  input  logic [dsrc_pkg::POS_W-1:0]    pos_a,
  input  logic [dsrc_pkg::POS_W-1:0]    pos_b,
  input  logic [1:0]                    symbol,
  output logic                          vld,
  output dsrc_pkg::s1_t                 s1
);
  import dsrc_pkg::*;

  logic             vld_r;
  s1_t              s1_r;
  s1_t              s1_nxt;
  logic [POS_W-1:0] pa;
  logic [POS_W-1:0] pb;

  always_comb begin
    pa            = sat_pos(pos_a);
    pb            = sat_pos(pos_b);
    s1_nxt.mode   = mode;
    s1_nxt.symbol = symbol;
    s1_nxt.lo     = (pa < pb) ? pa : pb;
    s1_nxt.hi     = (pa < pb) ? pb : pa;
    s1_nxt.syms   = {bits_0, bits_1, bits_2, bits_3};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_r <= s1_nxt;
    end
  end

  assign vld = vld_r;
  assign s1  = s1_r;

endmodule

// ----- hdl/dsrc_match.sv -----
// ---------------------------------------------------------------------------
// dsrc_match
// Stage 2: range mask and match bits for the selected symbol, c, g and t at all 128 positions.
// ---------------------------------------------------------------------------
module dsrc_match (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_in,
  input  dsrc_pkg::s1_t s1,
  output logic          vld,
  output dsrc_pkg::s2_t s2
);
  import dsrc_pkg::*;

  logic vld_r;
  s2_t  s2_r;
  s2_t  s2_nxt;

  always_comb begin
    logic       in_rng;
    logic [1:0] code;
    s2_nxt.mode = s1.mode;
    s2_nxt.len  = s1.hi - s1.lo;
    s2_nxt.hits = '0;
    for (int k = 0; k < SYMS; k++) begin
      // earliest symbol sits in the top bits of the block
      code   = s1.syms[BLOCK_W-1-2*k -: 2];
      in_rng = (POS_W'(k) >= s1.lo) && (POS_W'(k) < s1.hi);
      s2_nxt.hits[LANE_SEL][k] = in_rng && (code == s1.symbol);
      s2_nxt.hits[LANE_C][k]   = in_rng && (code == SYM_C);
      s2_nxt.hits[LANE_G][k]   = in_rng && (code == SYM_G);
      s2_nxt.hits[LANE_T][k]   = in_rng && (code == SYM_T);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_in) begin
      s2_r <= s2_nxt;
    end
  end

  assign vld = vld_r;
  assign s2  = s2_r;

endmodule

// ----- hdl/dsrc_popcount.sv -----
// ---------------------------------------------------------------------------
// dsrc_popcount
// Stages 3 and 4: 16-bit chunk popcounts, then sum of the chunks per lane.
// ---------------------------------------------------------------------------
module dsrc_popcount (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_in,
  input  dsrc_pkg::s2_t s2,
  output logic          vld,
  output dsrc_pkg::s4_t s4
);
  import dsrc_pkg::*;

  logic vld3_r;
  logic vld4_r;
  s3_t  s3_r;
  s3_t  s3_nxt;
  s4_t  s4_r;
  s4_t  s4_nxt;

  always_comb begin
    s3_nxt.mode = s2.mode;
    s3_nxt.len  = s2.len;
    for (int l = 0; l < N_LANE; l++) begin
      for (int c = 0; c < N_CHUNK; c++) begin
        s3_nxt.part[l][c] = pop_chunk(s2.hits[l][c*CHUNK_W +: CHUNK_W]);
      end
    end
  end

  always_comb begin
    s4_nxt.mode = s3_r.mode;
    s4_nxt.len  = s3_r.len;
    for (int l = 0; l < N_LANE; l++) begin
      s4_nxt.cnt[l] = '0;
      for (int c = 0; c < N_CHUNK; c++) begin
        s4_nxt.cnt[l] = s4_nxt.cnt[l] + CNT_W'(s3_r.part[l][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld3_r <= vld_in;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_in) begin
      s3_r <= s3_nxt;
    end
    if (vld3_r) begin
      s4_r <= s4_nxt;
    end
  end

  assign vld = vld4_r;
  assign s4  = s4_r;

endmodule
